>>> rtl/core/deq_pkg.sv
package deq_pkg;

    // Storage defaults
    localparam int DEPTH_DEF      = 64;
    localparam int DATA_WIDTH_DEF = 32;

    // Field widths of one beat
    localparam int ACTION_W = 3;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 6;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    // Slave-side tdata layout
    localparam int ACT_LSB   = 0;
    localparam int DATA_LSB  = ACT_LSB + ACTION_W;
    localparam int POS_LSB   = DATA_LSB + VALUE_W;
    localparam int S_USED_W  = POS_LSB + POS_W;
    localparam int S_TDATA_W = ((S_USED_W + 7) / 8) * 8;

    // Master-side tdata layout
    localparam int RVAL_LSB  = 0;
    localparam int STAT_LSB  = RVAL_LSB + VALUE_W;
    localparam int CNT_LSB   = STAT_LSB + STATUS_W;
    localparam int M_USED_W  = CNT_LSB + COUNT_W;
    localparam int M_TDATA_W = ((M_USED_W + 7) / 8) * 8;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUSH_BACK  = 3'd0,
        ACT_PUSH_FRONT = 3'd1,
        ACT_POP_BACK   = 3'd2,
        ACT_POP_FRONT  = 3'd3,
        ACT_READ       = 3'd4
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    // Controller -> datapath
    typedef struct packed {
        logic exec;         // apply the beat on the slave side
        logic load_direct;  // result known now, load output register
        logic load_read;    // load output register from RAM read data
    } deq_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic read_hit;     // beat on the slave side is an in-range read
        logic out_free;     // output register can take a result this cycle
    } deq_sts_t;

endpackage

>>> rtl/core/deq_ram.sv
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/deq_ctrl.sv
module deq_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  deq_pkg::deq_sts_t sts,
    output deq_pkg::deq_cmd_t cmd
);
    import deq_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_READ
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = sts.out_free;
                if (s_tvalid && sts.out_free) begin
                    cmd.exec = 1'b1;
                    // in-range reads wait in S_READ for the registered RAM read
                    if (sts.read_hit) begin
                        state_next = S_READ;
                    end else begin
                        cmd.load_direct = 1'b1;
                    end
                end
            end
            S_READ: begin
                if (sts.out_free) begin
                    cmd.load_read = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/core/deq_datapath.sv
module deq_datapath #(
    parameter int DEPTH      = deq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [deq_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [deq_pkg::M_TDATA_W-1:0] m_tdata,
    input  deq_pkg::deq_cmd_t             cmd,
    output deq_pkg::deq_sts_t             sts
);
    import deq_pkg::*;

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int SW   = AW + 1;
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;

    action_t              action;
    logic [VALUE_W-1:0]   data_value;
    logic [POS_W-1:0]     position;

    logic [AW-1:0]        front_reg, front_next;
    logic [CW-1:0]        count_reg, count_next;

    logic                 full, empty, read_hit;
    logic [SW-1:0]        back_sum, read_sum;
    logic [AW-1:0]        back_slot, read_slot, front_dec, front_inc;
    status_t              status;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [DATA_WIDTH-1:0] ram_rdata;

    logic                 out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0]   out_value_reg, out_value_next;
    status_t              out_status_reg, out_status_next;
    logic [COUNT_W-1:0]   out_count_reg, out_count_next;

    assign action     = action_t'(s_tdata[ACT_LSB +: ACTION_W]);
    assign data_value = s_tdata[DATA_LSB +: VALUE_W];
    assign position   = s_tdata[POS_LSB +: POS_W];

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);

    // ring slots: sum stays below twice the depth, so one compare-subtract wraps it
    assign back_sum  = SW'(front_reg) + SW'(count_reg);
    assign back_slot = (back_sum >= SW'(DEPTH)) ? AW'(back_sum - SW'(DEPTH)) : AW'(back_sum);
    assign read_sum  = SW'(front_reg) + SW'(position);
    assign read_slot = (read_sum >= SW'(DEPTH)) ? AW'(read_sum - SW'(DEPTH)) : AW'(read_sum);

    assign front_dec = (front_reg == '0) ? AW'(DEPTH - 1) : front_reg - AW'(1);
    assign front_inc = (front_reg == AW'(DEPTH - 1)) ? '0 : front_reg + AW'(1);

    assign read_hit = (action == ACT_READ) && (CMPW'(position) < CMPW'(count_reg));

    always_comb begin
        front_next = front_reg;
        count_next = count_reg;
        status     = ST_OK;
        ram_we     = 1'b0;
        ram_waddr  = back_slot;
        unique case (action)
            ACT_PUSH_BACK: begin
                if (full) begin
                    status = ST_FULL;
                end else begin
                    ram_we     = 1'b1;
                    count_next = count_reg + CW'(1);
                end
            end
            ACT_PUSH_FRONT: begin
                if (full) begin
                    status = ST_FULL;
                end else begin
                    ram_we     = 1'b1;
                    ram_waddr  = front_dec;
                    front_next = front_dec;
                    count_next = count_reg + CW'(1);
                end
            end
            ACT_POP_BACK: begin
                if (empty) begin
                    status = ST_EMPTY;
                end else begin
                    count_next = count_reg - CW'(1);
                end
            end
            ACT_POP_FRONT: begin
                if (empty) begin
                    status = ST_EMPTY;
                end else begin
                    front_next = front_inc;
                    count_next = count_reg - CW'(1);
                end
            end
            ACT_READ: begin
                if (!read_hit) begin
                    status = ST_RANGE;
                end
            end
            default: begin
                // unknown action: no change, reports ok
            end
        endcase
    end

    deq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (aclk),
        .we    (cmd.exec && ram_we),
        .waddr (ram_waddr),
        .wdata (DATA_WIDTH'(data_value)),
        .re    (cmd.exec && read_hit),
        .raddr (read_slot),
        .rdata (ram_rdata)
    );

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;
        if (cmd.load_direct) begin
            out_valid_next  = 1'b1;
            out_value_next  = '0;
            out_status_next = status;
            out_count_next  = COUNT_W'(count_next);
        end else if (cmd.load_read) begin
            out_valid_next  = 1'b1;
            out_value_next  = VALUE_W'(ram_rdata);
            out_status_next = ST_OK;
            out_count_next  = COUNT_W'(count_reg);
        end else if (m_tready) begin
            out_valid_next  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_reg     <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.exec) begin
                front_reg <= front_next;
                count_reg <= count_next;
            end
            out_valid_reg <= out_valid_next;
        end
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
        out_count_reg  <= out_count_next;
    end

    assign sts.read_hit = read_hit;
    assign sts.out_free = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - M_USED_W){1'b0}}, out_count_reg, out_status_reg,
                       out_value_reg};

endmodule

>>> rtl/core/double_ended_queue.sv
// Double-ended queue on a circular buffer of DEPTH entries of DATA_WIDTH bits.
// Slave side: one beat is one action - push back, push front, pop back,
// pop front, or read the element at an offset from the front.
// Master side: one beat per action with read value, status and element count.
// Result timing:
//   pushes, pops, failed reads and unknown actions: result registered at the
//   accepting edge, one action per cycle while the output is not stalled;
//   reads in range: result loaded from the registered read port of the element
//   RAM in the S_READ state (no beat is taken while the read is in flight).
// Reset: queue empty, front at slot 0, no result pending. Element RAM is not
// cleared; only slots holding live elements are ever read.
// Back-pressure: a result waiting in the output register is held until
// m_tready; while it waits s_tready stays low, so one result is taken and a
// new action accepted in the same cycle when m_tready is high.
module double_ended_queue #(
    parameter int DEPTH      = deq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [2:0] action, [34:3] data_value, [40:35] position, [47:41] zero
    input  logic [deq_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [31:0] read_value, [33:32] status, [40:34] element_count, [47:41] zero
    output logic [deq_pkg::M_TDATA_W-1:0] m_tdata
);
    import deq_pkg::*;

    deq_cmd_t cmd;
    deq_sts_t sts;

    deq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    deq_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .sts      (sts)
    );

endmodule

>>> rtl/core/deq_checker.sv
module deq_checker #(
    parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [deq_pkg::M_TDATA_W-1:0] m_tdata
);
    import deq_pkg::*;

    logic [VALUE_W-1:0]  rval;
    logic [STATUS_W-1:0] stat;
    logic [COUNT_W-1:0]  cnt;

    assign rval = m_tdata[RVAL_LSB +: VALUE_W];
    assign stat = m_tdata[STAT_LSB +: STATUS_W];
    assign cnt  = m_tdata[CNT_LSB +: COUNT_W];

    // stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // no action taken while a result is stuck in the output register
    a_no_accept_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("slave side ready while output stalled");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (stat != ST_OK) |-> rval == '0)
        else $error("failed action returned non-zero value");

    a_empty_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (stat == ST_EMPTY) |-> cnt == '0)
        else $error("empty status with non-zero count");

    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (stat == ST_FULL) |-> cnt == COUNT_W'(DEPTH))
        else $error("full status with count below depth");

endmodule

bind double_ended_queue deq_checker #(
    .DEPTH (DEPTH)
) u_deq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> tb/sv/double_ended_queue_test.sv
`timescale 1ns / 100ps

module double_ended_queue_test;
    import deq_pkg::*;

    localparam int DEPTH       = DEPTH_DEF;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 200;
    localparam int NUM_ITEMS   = 1100;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        status_t            status;
        logic [COUNT_W-1:0] count;
    } deq_result_t;

    // Tracks the ring contents and the results still owed by the block
    class deque_tracker;
        logic [VALUE_W-1:0] ring [DEPTH];
        int                 front;
        int                 held;
        int                 errors;
        deq_result_t        due_results [$];

        function new();
            front  = 0;
            held   = 0;
            errors = 0;
        endfunction

        function int pending();
            return due_results.size();
        endfunction

        function void note_action(logic [ACTION_W-1:0] act, logic [VALUE_W-1:0] value,
                                  logic [POS_W-1:0] pos);
            deq_result_t res;
            res.value  = '0;
            res.status = ST_OK;
            case (act)
                ACT_PUSH_BACK: begin
                    if (held >= DEPTH) begin
                        res.status = ST_FULL;
                    end else begin
                        ring[(front + held) % DEPTH] = value;
                        held++;
                    end
                end
                ACT_PUSH_FRONT: begin
                    if (held >= DEPTH) begin
                        res.status = ST_FULL;
                    end else begin
                        front = (front == 0) ? DEPTH - 1 : front - 1;
                        ring[front] = value;
                        held++;
                    end
                end
                ACT_POP_BACK: begin
                    if (held == 0)
                        res.status = ST_EMPTY;
                    else
                        held--;
                end
                ACT_POP_FRONT: begin
                    if (held == 0) begin
                        res.status = ST_EMPTY;
                    end else begin
                        front = (front + 1) % DEPTH;
                        held--;
                    end
                end
                ACT_READ: begin
                    if (int'(pos) >= held)
                        res.status = ST_RANGE;
                    else
                        res.value = ring[(front + int'(pos)) % DEPTH];
                end
                default: ;
            endcase
            res.count = COUNT_W'(held);
            due_results.insert(due_results.size(), res);
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] beat);
            deq_result_t want;
            if (due_results.size() == 0) begin
                $error("result beat %h arrived with nothing outstanding", beat);
                errors++;
                return;
            end
            want = due_results[0];
            due_results.delete(0);
            if (beat[RVAL_LSB +: VALUE_W] !== want.value) begin
                $error("read_value: expected %h, got %h", want.value, beat[RVAL_LSB +: VALUE_W]);
                errors++;
            end
            if (beat[STAT_LSB +: STATUS_W] !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, beat[STAT_LSB +: STATUS_W]);
                errors++;
            end
            if (beat[CNT_LSB +: COUNT_W] !== want.count) begin
                $error("element_count: expected %0d, got %0d", want.count,
                       beat[CNT_LSB +: COUNT_W]);
                errors++;
            end
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;

    deque_tracker tracker;
    bit           hold_off = 1'b0;
    int           idle_cycles = 0;

    double_ended_queue uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
    end

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Result check comes first: a result never belongs to the beat taken at the same edge
    always @(posedge aclk) begin
        if (aresetn === 1'b1) begin
            if (m_tvalid === 1'b1 && m_tready === 1'b1)
                tracker.check_result(m_tdata);
            if (s_tvalid === 1'b1 && s_tready === 1'b1)
                tracker.note_action(s_tdata[ACT_LSB +: ACTION_W], s_tdata[DATA_LSB +: VALUE_W],
                                    s_tdata[POS_LSB +: POS_W]);
        end
        if ((s_tvalid === 1'b1 && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready === 1'b1))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Receiver: draws its stall style at random, with one long hold on request
    initial begin : result_sink
        int cyc;
        int style;
        int hold_left;
        bit hold_done;
        cyc       = 0;
        style     = 0;
        hold_left = 0;
        hold_done = 1'b0;
        m_tready  = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (cyc % 256 == 0)
                style = $urandom_range(0, 3);
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                case (style)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 3) != 0);
                    2: m_tready <= ($urandom_range(0, 9) < 3);
                    default: m_tready <= (cyc % 3 == 0);
                endcase
            end
            cyc++;
        end
    end

    // Called at a falling edge; returns at the falling edge after the beat is taken
    task automatic send_action(input logic [ACTION_W-1:0] act, input logic [VALUE_W-1:0] value,
                               input logic [POS_W-1:0] pos);
        logic [S_TDATA_W-1:0] beat;
        beat = '0;
        beat[ACT_LSB +: ACTION_W] = act;
        beat[DATA_LSB +: VALUE_W] = value;
        beat[POS_LSB +: POS_W]    = pos;
        s_tvalid <= 1'b1;
        s_tdata  <= beat;
        do @(posedge aclk); while (s_tready !== 1'b1);
        @(negedge aclk);
    endtask

    task automatic pause_sender(input int cycles);
        if (cycles > 0) begin
            s_tvalid <= 1'b0;
            s_tdata  <= S_TDATA_W'({$urandom, $urandom});
            repeat (cycles) @(negedge aclk);
        end
    endtask

    initial begin : stimulus
        int                  sent;
        int                  mode;
        int                  phase_len;
        int                  burst_left;
        int                  push_pct;
        int                  pick;
        logic [ACTION_W-1:0] act;
        logic [POS_W-1:0]    pos;

        tracker  = new();
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // empty queue, unknown codes, wrap of the front pointer below slot 0
        send_action(ACT_POP_BACK, $urandom, 6'd0);
        send_action(ACT_POP_FRONT, $urandom, 6'd63);
        send_action(ACT_READ, $urandom, 6'd0);
        send_action(3'd5, 32'hFFFF_FFFF, 6'd63);
        send_action(3'd6, $urandom, POS_W'($urandom));
        send_action(3'd7, 32'h0, 6'd0);
        send_action(ACT_PUSH_FRONT, 32'hFFFF_FFFF, 6'd63);
        send_action(ACT_PUSH_BACK, 32'h0000_0000, 6'd0);
        send_action(ACT_PUSH_FRONT, 32'h8000_0001, 6'd21);
        send_action(ACT_PUSH_BACK, 32'h7FFF_FFFE, 6'd42);
        send_action(ACT_READ, $urandom, 6'd0);
        send_action(ACT_READ, $urandom, 6'd1);
        send_action(ACT_READ, $urandom, 6'd2);
        send_action(ACT_READ, $urandom, 6'd3);
        send_action(ACT_READ, $urandom, 6'd4);
        send_action(ACT_READ, $urandom, 6'd63);
        send_action(ACT_POP_FRONT, $urandom, 6'd0);
        send_action(ACT_POP_BACK, $urandom, 6'd0);
        send_action(ACT_READ, $urandom, 6'd1);
        send_action(ACT_READ, $urandom, 6'd2);
        send_action(ACT_POP_BACK, $urandom, 6'd0);
        send_action(ACT_POP_FRONT, $urandom, 6'd0);
        send_action(ACT_POP_FRONT, $urandom, 6'd0);

        // receiver holds off while the sender keeps offering beats
        hold_off   = 1'b1;
        sent       = 0;
        burst_left = 0;
        while (sent < NUM_ITEMS) begin
            mode      = $urandom_range(0, 2);
            phase_len = $urandom_range(60, 160);
            case (mode)
                0: push_pct = 70;   // filling
                1: push_pct = 15;   // draining
                default: push_pct = 42;
            endcase
            repeat (phase_len) begin
                if (burst_left == 0) begin
                    pause_sender(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8));
                    burst_left = $urandom_range(1, 40);
                end
                pick = $urandom_range(0, 99);
                pos  = POS_W'($urandom_range(0, 63));
                if (pick < push_pct) begin
                    act = $urandom_range(0, 1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT;
                end else if (pick < push_pct + 16) begin
                    act = ACT_READ;
                    if (tracker.held != 0 && $urandom_range(0, 9) < 8)
                        pos = POS_W'($urandom_range(0, tracker.held - 1));
                end else if (pick < push_pct + 18) begin
                    act = ACTION_W'($urandom_range(5, 7));
                end else begin
                    act = $urandom_range(0, 1) ? ACT_POP_BACK : ACT_POP_FRONT;
                end
                send_action(act, $urandom, pos);
                burst_left--;
                if (act <= ACT_READ)
                    sent++;
            end
        end

        s_tvalid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
        if (tracker.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

>>> double_ended_queue.f
rtl/core/deq_pkg.sv
rtl/core/deq_ram.sv
rtl/core/deq_ctrl.sv
rtl/core/deq_datapath.sv
rtl/core/double_ended_queue.sv
rtl/core/deq_checker.sv
tb/sv/double_ended_queue_test.sv
